// File: rtl/tswq_pkg.sv
// Shared types and constants for the timed sleep/wakeup queue.
// Holds field widths, status codes and the controller/datapath interface structs.
// No dependencies.
package tswq_pkg;

    localparam int TIME_W = 40;
    localparam int DUR_W  = 32;
    localparam int STAT_W = 2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_TICK = 2'd0;
    localparam logic [STAT_W-1:0] ST_OK   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic              capture;    // latch the accepted input transaction
        logic              insert;     // insert captured entry into the sorted chain
        logic              pop;        // drop the head entry
        logic              out_load;   // load the result register
        logic [STAT_W-1:0] out_status;
        logic              out_woken;
        logic              out_last;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic full;      // every cell holds an entry
        logic head_due;  // head entry wakes at or before captured now
        logic next_due;  // second entry wakes at or before captured now
        logic out_free;  // result register can take a new result
    } sts_t;

endpackage

// File: rtl/tswq_ctrl.sv
// Controller for the timed sleep/wakeup queue.
// Sequences capture, insert and pop; depends on tswq_pkg.
module tswq_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          s_action,
    input  tswq_pkg::sts_t sts,
    output tswq_pkg::cmd_t cmd
);
    import tswq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SLEEP = 3'b010,
        S_TICK  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands
    always_comb begin
        state_next     = state_reg;
        s_ready        = 1'b0;
        cmd            = '0;
        cmd.out_status = ST_TICK;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = s_action ? S_TICK : S_SLEEP;
                end
            end
            S_SLEEP: begin
                if (sts.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_last   = 1'b1;
                    cmd.insert     = !sts.full;
                    cmd.out_status = sts.full ? ST_FULL : ST_OK;
                    state_next     = S_IDLE;
                end
            end
            S_TICK: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    if (sts.head_due) begin
                        cmd.pop       = 1'b1;
                        cmd.out_woken = 1'b1;
                        cmd.out_last  = !sts.next_due;
                        state_next    = sts.next_due ? S_TICK : S_IDLE;
                    end else begin
                        cmd.out_last = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // A pop is only issued while ticking and only for a due head
    a_pop_in_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> (state_reg == S_TICK) && sts.head_due)
        else $error("pop outside of a due tick");

    // A sleep always finishes in one result and returns to idle
    a_sleep_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SLEEP) && sts.out_free |=> state_reg == S_IDLE)
        else $error("sleep did not return to idle");

    // New transactions are never taken in the same cycle as a result load, insert or pop
    a_capture_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |-> !cmd.out_load && !cmd.insert && !cmd.pop)
        else $error("capture overlapped other work");

endmodule

// File: rtl/tswq_dpath.sv
// Datapath for the timed sleep/wakeup queue: sorted cell chain,
// captured input and result register. Depends on tswq_pkg.
module tswq_dpath #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 10
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [ID_BITS-1:0]           s_sleeper_id,
    input  logic [tswq_pkg::TIME_W-1:0]  s_now,
    input  logic [tswq_pkg::DUR_W-1:0]   s_duration,
    input  tswq_pkg::cmd_t               cmd,
    output tswq_pkg::sts_t               sts,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_woken_valid,
    output logic [ID_BITS-1:0]           m_woken_id,
    output logic [tswq_pkg::STAT_W-1:0]  m_status,
    output logic                         m_last
);
    import tswq_pkg::*;

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [OCC_W-1:0] OCC_MAX = OCC_W'(QUEUE_DEPTH);
    localparam logic [OCC_W-1:0] OCC_ONE = OCC_W'(1);

    // Sorted cells, earliest wakeup at index 0
    logic [TIME_W-1:0]  time_reg [QUEUE_DEPTH];
    logic [ID_BITS-1:0] id_reg   [QUEUE_DEPTH];
    logic [OCC_W-1:0]   occ_reg;

    // Captured transaction
    logic [TIME_W-1:0]  now_reg;
    logic [TIME_W-1:0]  wake_reg;
    logic [ID_BITS-1:0] sid_reg;

    // Result register
    logic               m_valid_reg;
    logic               woken_reg;
    logic [ID_BITS-1:0] wid_reg;
    logic [STAT_W-1:0]  stat_reg;
    logic               last_reg;

    logic [TIME_W:0]    wake_sum;
    logic [TIME_W-1:0]  wake_sat;
    logic [QUEUE_DEPTH-1:0] le;

    // Saturating wakeup time
    always_comb begin
        wake_sum = {1'b0, s_now} + {{(TIME_W + 1 - DUR_W){1'b0}}, s_duration};
        wake_sat = wake_sum[TIME_W] ? {TIME_W{1'b1}} : wake_sum[TIME_W-1:0];
    end

    // Per-cell compare: occupied and not later than the new wakeup
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            le[i] = (OCC_W'(i) < occ_reg) && (time_reg[i] <= wake_reg);
        end
    end

    // Status toward the controller
    always_comb begin
        sts.full     = (occ_reg == OCC_MAX);
        sts.head_due = (occ_reg != '0) && (time_reg[0] <= now_reg);
        sts.next_due = (occ_reg > OCC_ONE) && (time_reg[1] <= now_reg);
        sts.out_free = !m_valid_reg || m_ready;
    end

    // Capture of the accepted transaction
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            now_reg  <= s_now;
            wake_reg <= wake_sat;
            sid_reg  <= s_sleeper_id;
        end
    end

    // Cell chain: insert shifts up behind the slot, pop shifts down
    always_ff @(posedge aclk) begin
        if (cmd.insert) begin
            if (!le[0]) begin
                time_reg[0] <= wake_reg;
                id_reg[0]   <= sid_reg;
            end
            for (int i = 1; i < QUEUE_DEPTH; i++) begin
                if (!le[i-1]) begin
                    time_reg[i] <= time_reg[i-1];
                    id_reg[i]   <= id_reg[i-1];
                end else if (!le[i]) begin
                    time_reg[i] <= wake_reg;
                    id_reg[i]   <= sid_reg;
                end
            end
        end else if (cmd.pop) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                time_reg[i] <= time_reg[i+1];
                id_reg[i]   <= id_reg[i+1];
            end
        end
    end

    // Occupancy count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else if (cmd.insert) begin
            occ_reg <= occ_reg + OCC_ONE;
        end else if (cmd.pop) begin
            occ_reg <= occ_reg - OCC_ONE;
        end
    end

    // Result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            woken_reg <= cmd.out_woken;
            wid_reg   <= cmd.out_woken ? id_reg[0] : '0;
            stat_reg  <= cmd.out_status;
            last_reg  <= cmd.out_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_woken_valid = woken_reg;
    assign m_woken_id    = wid_reg;
    assign m_status      = stat_reg;
    assign m_last        = last_reg;

    // Count never runs past the number of cells
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_MAX)
        else $error("occupancy past queue depth");

    // No insert into a full chain, no pop from an empty one
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.insert && sts.full) && !(cmd.pop && (occ_reg == '0)))
        else $error("insert when full or pop when empty");

    // Result register is never overwritten while its transaction waits
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !m_valid_reg || m_ready)
        else $error("pending result overwritten");

    // Chain stays sorted at the head
    a_sorted_head: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg > OCC_ONE |-> time_reg[0] <= time_reg[1])
        else $error("head entries out of order");

endmodule

// File: rtl/timed_sleep_wakeup_queue.sv
// Timed sleep/wakeup queue top level: controller plus datapath.
// Depends on tswq_pkg, tswq_ctrl and tswq_dpath.
//
// Usage:
//   Input channel (s_*): one transaction is a sleep request (s_action 0) with
//   id, current time and duration, or a timer tick (s_action 1) with the
//   current time. Result channel (m_*): one transaction per result.
//   A sleep gives a single result, status accepted or full, with m_last set.
//   A tick gives one result per entry whose wakeup time is not later than
//   s_now, earliest first and in arrival order for equal times, m_last on the
//   final one; a tick with nothing due gives one empty result.
//   Timing: the input is captured when it is accepted, and its result is
//   registered once the result register is free; each further woken entry
//   is loaded as the one before it is taken. The controller handles
//   one input at a time and takes no new input until the last result of
//   the current one is loaded into the one-result register.
//   Insertion into the sorted cell chain updates every cell in parallel.
//   Reset empties the queue; cell contents need no clearing.
//   When the receiver stalls, the held result waits and the next result is
//   not produced; one further input is still accepted meanwhile.
module timed_sleep_wakeup_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 10
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_action,
    input  logic [ID_BITS-1:0]           s_sleeper_id,
    input  logic [tswq_pkg::TIME_W-1:0]  s_now,
    input  logic [tswq_pkg::DUR_W-1:0]   s_duration,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_woken_valid,
    output logic [ID_BITS-1:0]           m_woken_id,
    output logic [tswq_pkg::STAT_W-1:0]  m_status,
    output logic                         m_last
);
    import tswq_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer
    tswq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Cell chain and result register
    tswq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_sleeper_id  (s_sleeper_id),
        .s_now         (s_now),
        .s_duration    (s_duration),
        .cmd           (cmd),
        .sts           (sts),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_woken_valid (m_woken_valid),
        .m_woken_id    (m_woken_id),
        .m_status      (m_status),
        .m_last        (m_last)
    );

endmodule

// File: test/tb_timed_sleep_wakeup_queue.sv
// Self-checking testbench for the timed sleep/wakeup queue: a directed table, then random
// sleep and tick traffic under varied idling and back-pressure, checked against a predictor.
// Depends on tswq_pkg and timed_sleep_wakeup_queue.
module tb_timed_sleep_wakeup_queue;

    import tswq_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int ID_BITS      = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 50;

    localparam logic ACT_SLEEP = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    localparam logic [TIME_W-1:0] NOW_MAX = {TIME_W{1'b1}};
    localparam logic [DUR_W-1:0]  DUR_MAX = {DUR_W{1'b1}};

    typedef struct packed {
        logic               action;
        logic [ID_BITS-1:0] id;
        logic [TIME_W-1:0]  now;
        logic [DUR_W-1:0]   duration;
    } request_t;

    typedef struct packed {
        logic               woken_valid;
        logic [ID_BITS-1:0] woken_id;
        logic [STAT_W-1:0]  status;
        logic               last;
    } result_t;

    typedef struct packed {
        request_t req;
        logic     typed;   // expected result written by hand below
        result_t  res;
    } row_t;

    localparam result_t R_EMPTY = '{woken_valid: 1'b0, woken_id: '0, status: ST_TICK, last: 1'b1};
    localparam result_t R_OK    = '{woken_valid: 1'b0, woken_id: '0, status: ST_OK, last: 1'b1};
    localparam result_t R_FULL  = '{woken_valid: 1'b0, woken_id: '0, status: ST_FULL, last: 1'b1};
    localparam result_t R_PRED  = '0;

    // Directed rows: extremes, saturation, equal times, fill to full, flush of all entries
    localparam row_t DIRECTED [25] = '{
        '{'{ACT_TICK,  10'd0,    40'd0,          32'd0},   1'b1, R_EMPTY},
        '{'{ACT_TICK,  10'd0,    NOW_MAX,        32'd0},   1'b1, R_EMPTY},
        '{'{ACT_SLEEP, 10'd0,    40'd0,          32'd0},   1'b1, R_OK},
        '{'{ACT_SLEEP, 10'd1023, NOW_MAX,        DUR_MAX}, 1'b1, R_OK},
        '{'{ACT_SLEEP, 10'd5,    NOW_MAX - 40'd10, 32'd20}, 1'b1, R_OK},
        '{'{ACT_SLEEP, 10'd7,    40'd100,        32'd0},   1'b1, R_OK},
        '{'{ACT_SLEEP, 10'd8,    40'd100,        32'd0},   1'b1, R_OK},
        '{'{ACT_TICK,  10'd0,    40'd100,        32'd0},   1'b0, R_PRED},
        '{'{ACT_SLEEP, 10'd100,  40'd1000,       32'd300}, 1'b1, R_OK},
        '{'{ACT_SLEEP, 10'd101,  40'd1000,       32'd100}, 1'b1, R_OK},
        '{'{ACT_SLEEP, 10'd102,  40'd1000,       32'd200}, 1'b1, R_OK},
        '{'{ACT_SLEEP, 10'd103,  40'd1000,       32'd100}, 1'b1, R_OK},
        '{'{ACT_SLEEP, 10'd104,  40'd1000,       32'd0},   1'b1, R_OK},
        '{'{ACT_SLEEP, 10'd512,  40'd1000,       32'd50},  1'b1, R_OK},
        '{'{ACT_SLEEP, 10'd256,  40'd1000,       32'd300}, 1'b1, R_OK},
        '{'{ACT_SLEEP, 10'd3,    40'd1000,       32'd1},   1'b1, R_OK},
        '{'{ACT_SLEEP, 10'd999,  40'd1000,       32'd100}, 1'b1, R_OK},
        '{'{ACT_SLEEP, 10'd341,  40'd1000,       32'd250}, 1'b1, R_OK},
        '{'{ACT_SLEEP, 10'd682,  40'd1000,       32'd75},  1'b1, R_OK},
        '{'{ACT_SLEEP, 10'd15,   40'd1000,       32'd0},   1'b1, R_OK},
        '{'{ACT_SLEEP, 10'd640,  40'd1000,       32'd500}, 1'b1, R_OK},
        '{'{ACT_SLEEP, 10'd1,    40'd1000,       32'd200}, 1'b1, R_OK},
        '{'{ACT_SLEEP, 10'd77,   40'd0,          32'd0},   1'b1, R_FULL},
        '{'{ACT_TICK,  10'd0,    40'd999,        32'd0},   1'b1, R_EMPTY},
        '{'{ACT_TICK,  10'd0,    NOW_MAX,        32'd0},   1'b0, R_PRED}
    };

    logic                aclk;
    logic                aresetn       = 1'b0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic                s_action      = ACT_SLEEP;
    logic [ID_BITS-1:0]  s_sleeper_id  = '0;
    logic [TIME_W-1:0]   s_now         = '0;
    logic [DUR_W-1:0]    s_duration    = '0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic                m_woken_valid;
    logic [ID_BITS-1:0]  m_woken_id;
    logic [STAT_W-1:0]   m_status;
    logic                m_last;

    // Predictor state: sleepers sorted by wakeup time
    logic [TIME_W-1:0]   sleep_wake [QUEUE_DEPTH];
    logic [ID_BITS-1:0]  sleep_id   [QUEUE_DEPTH];
    int                  sleep_count = 0;

    result_t             pending_results [$];
    int                  mismatch_count  = 0;
    int                  cycle_count     = 0;
    int                  sender_idle_pct = 0;
    int                  stall_pct       = 0;
    logic                hold_off        = 1'b0;
    logic [TIME_W-1:0]   clock_now       = '0;

    timed_sleep_wakeup_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_sleeper_id  (s_sleeper_id),
        .s_now         (s_now),
        .s_duration    (s_duration),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_woken_valid (m_woken_valid),
        .m_woken_id    (m_woken_id),
        .m_status      (m_status),
        .m_last        (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Work out the results of one accepted request and update the sleeper list
    function automatic void predict_wakeups(input request_t r);
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] wake;
        result_t           res;
        int                pos;
        int                due;
        int                i;
        if (r.action == ACT_SLEEP) begin
            sum  = {1'b0, r.now} + {{(TIME_W + 1 - DUR_W){1'b0}}, r.duration};
            wake = sum[TIME_W] ? NOW_MAX : sum[TIME_W-1:0];
            if (sleep_count >= QUEUE_DEPTH) begin
                pending_results.push_back(R_FULL);
            end else begin
                // new entry goes after all entries with an equal or earlier time
                pos = 0;
                while (pos < sleep_count && sleep_wake[pos] <= wake) pos++;
                for (i = sleep_count; i > pos; i--) begin
                    sleep_wake[i] = sleep_wake[i-1];
                    sleep_id[i]   = sleep_id[i-1];
                end
                sleep_wake[pos] = wake;
                sleep_id[pos]   = r.id;
                sleep_count++;
                pending_results.push_back(R_OK);
            end
        end else begin
            due = 0;
            while (due < sleep_count && sleep_wake[due] <= r.now) due++;
            if (due == 0) begin
                pending_results.push_back(R_EMPTY);
            end else begin
                for (i = 0; i < due; i++) begin
                    res.woken_valid = 1'b1;
                    res.woken_id    = sleep_id[i];
                    res.status      = ST_TICK;
                    res.last        = (i == due - 1);
                    pending_results.push_back(res);
                end
                for (i = due; i < sleep_count; i++) begin
                    sleep_wake[i-due] = sleep_wake[i];
                    sleep_id[i-due]   = sleep_id[i];
                end
                sleep_count -= due;
            end
        end
    endfunction

    // Mostly a running clock with short sleeps; the rest is noise over full field ranges
    function automatic request_t random_request();
        request_t    r;
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        r.id = ID_BITS'($urandom_range(0, (1 << ID_BITS) - 1));
        if ($urandom_range(99) < 80) begin
            clock_now = clock_now + TIME_W'($urandom_range(0, 12));
            r.now     = clock_now;
            r.action  = ($urandom_range(99) < 62) ? ACT_SLEEP : ACT_TICK;
            r.duration = ($urandom_range(9) == 0) ? DUR_W'($urandom)
                                                  : DUR_W'($urandom_range(0, 60));
        end else begin
            r.action   = $urandom_range(1) ? ACT_TICK : ACT_SLEEP;
            r.now      = wide[TIME_W-1:0];
            r.duration = DUR_W'($urandom);
        end
        return r;
    endfunction

    // Offer one transaction, with random idle cycles ahead of it, and wait for acceptance
    task automatic offer_request(input request_t r);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= r.action;
        s_sleeper_id <= r.id;
        s_now        <= r.now;
        s_duration   <= r.duration;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Compare one accepted result against the oldest expectation
    task automatic check_result();
        result_t exp;
        if (pending_results.size() == 0) begin
            $error("result transaction with nothing expected: id %0d status %0d",
                   m_woken_id, m_status);
            mismatch_count++;
        end else begin
            exp = pending_results.pop_front();
            if (m_woken_valid !== exp.woken_valid) begin
                $error("woken_valid: expected %0d, got %0d", exp.woken_valid, m_woken_valid);
                mismatch_count++;
            end
            if (m_woken_id !== exp.woken_id) begin
                $error("woken_id: expected %0d, got %0d", exp.woken_id, m_woken_id);
                mismatch_count++;
            end
            if (m_status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, m_status);
                mismatch_count++;
            end
            if (m_last !== exp.last) begin
                $error("last: expected %0d, got %0d", exp.last, m_last);
                mismatch_count++;
            end
        end
    endtask

    // Result side: check, then choose ready for the next cycle
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            check_result();
        end
        m_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        request_t    r;
        logic [63:0] wide;
        int          phase;
        int          n;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table; typed rows swap the predicted result for the written one
        for (n = 0; n < $size(DIRECTED); n++) begin
            offer_request(DIRECTED[n].req);
            predict_wakeups(DIRECTED[n].req);
            if (DIRECTED[n].typed) begin
                void'(pending_results.pop_back());
                pending_results.push_back(DIRECTED[n].res);
            end
        end

        // Random phases: no idling, sender idle, receiver stall, both, long hold-off
        for (phase = 0; phase < 5; phase++) begin
            wide = {$urandom, $urandom};
            case (phase)
                0: begin
                    sender_idle_pct = 0;
                    stall_pct       <= 0;
                    clock_now       = wide[TIME_W-1:0] >> 8;
                end
                1: begin
                    sender_idle_pct = 56;
                    stall_pct       <= 0;
                    clock_now       = wide[TIME_W-1:0];
                end
                2: begin
                    sender_idle_pct = 0;
                    stall_pct       <= 56;
                    clock_now       = wide[TIME_W-1:0] >> 20;
                end
                3: begin
                    // close to the top so wakeup times saturate
                    sender_idle_pct = 38;
                    stall_pct       <= 38;
                    clock_now       = NOW_MAX - 40'd600;
                end
                default: begin
                    sender_idle_pct = 0;
                    stall_pct       <= 0;
                    clock_now       = wide[TIME_W-1:0];
                    hold_off        <= 1'b1;
                    fork
                        begin
                            repeat (HOLD_CYCLES) @(posedge aclk);
                            hold_off <= 1'b0;
                        end
                    join_none
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                r = random_request();
                offer_request(r);
                predict_wakeups(r);
            end
        end

        s_valid   <= 1'b0;
        stall_pct <= 0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: timed_sleep_wakeup_queue.f
rtl/tswq_pkg.sv
rtl/tswq_ctrl.sv
rtl/tswq_dpath.sv
rtl/timed_sleep_wakeup_queue.sv
test/tb_timed_sleep_wakeup_queue.sv
